// ----- hw/rtl/tplw_pkg.sv -----
// Shared types, constants and constant functions of the truncated power-law weight block.
`timescale 1ns / 1ps
`default_nettype none

package tplw_pkg;

  typedef enum logic [1:0] {
    CFG_OFFSET = 2'd0,
    CFG_DECAY  = 2'd1,
    CFG_CUTOFF = 2'd2
  } cfg_idx_e;

  localparam logic [31:0] OFFSET_RST = 32'd380109;
  localparam logic [15:0] DECAY_RST  = 16'd6758;
  localparam logic [31:0] CUTOFF_RST = 32'd22937600;

  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

  localparam int LogStages  = 16;
  localparam int DivStages  = 17;
  localparam int ExpStages  = 16;
  localparam int FrontDepth = LogStages + 2;

  typedef struct packed {
    logic        row_end;
    logic        dzero;
    logic [15:0] beta;
  } side_t;

  typedef struct packed {
    logic row_end;
    logic dzero;
    logic big;
    logic tiny;
  } tail_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] t;
    rem = v;
    r   = '0;
    b   = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      t = r + b;
      if (rem >= t) begin
        rem = rem - t;
        r   = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Root k of two in Q2.30, each one the square root of the one before.
  function automatic logic [31:0] exp2_root(input int k);
    logic [63:0] r;
    r = 64'h8000_0000;
    for (int i = 1; i <= 16; i++) begin
      if (i <= k) begin
        r = isqrt64(r << 30);
      end
    end
    return r[31:0];
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/tplw_log2.sv -----
// Pipelined base-2 logarithm of a 33-bit Q17.16 value by repeated squaring.
`timescale 1ns / 1ps
`default_nettype none

module tplw_log2 import tplw_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [32:0]        s_i,
  output logic signed [22:0] l_o
);

  logic [32:0] s_q;
  logic [5:0]  p0_q;
  logic [5:0]  p_d;
  logic [31:0] m0_d;

  logic [31:0] m_q  [LogStages+1];
  logic [15:0] fr_q [LogStages+1];
  logic [5:0]  pp_q [LogStages+1];

  always_comb begin
    p_d = '0;
    for (int i = 0; i < 33; i++) begin
      if (s_i[i]) begin
        p_d = 6'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q  <= s_i;
      p0_q <= p_d;
    end
  end

  always_comb begin
    if (p0_q >= 6'd31) begin
      m0_d = 32'(s_q >> (p0_q - 6'd31));
    end else begin
      m0_d = 32'({31'b0, s_q} << (6'd31 - p0_q));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0]  <= m0_d;
      fr_q[0] <= '0;
      pp_q[0] <= p0_q;
    end
  end

  for (genvar k = 1; k <= LogStages; k++) begin : g_sq
    logic [63:0] sq;
    logic [32:0] t;
    assign sq = 64'(m_q[k-1]) * 64'(m_q[k-1]);
    assign t  = sq[63:31];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[k]  <= t[32] ? t[32:1] : t[31:0];
        fr_q[k] <= {fr_q[k-1][14:0], t[32]};
        pp_q[k] <= pp_q[k-1];
      end
    end
  end

  logic signed [6:0] expo;
  assign expo = $signed({1'b0, pp_q[LogStages]}) - 7'sd16;
  assign l_o  = {expo, fr_q[LogStages]};

endmodule

`default_nettype wire

// ----- hw/rtl/tplw_div.sv -----
// Pipelined radix-4 restoring divider giving the distance over the cutoff in Q17.16.
`timescale 1ns / 1ps
`default_nettype none

module tplw_div import tplw_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] d_i,
  input  logic [31:0] kap_i,
  output logic [32:0] q_o,
  output logic        sat_o
);

  logic [47:0] rem_q [DivStages+1];
  logic [31:0] kap_q [DivStages+1];
  logic [32:0] qt_q  [DivStages+1];
  logic        sat_q [DivStages+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= {d_i, 16'b0};
      kap_q[0] <= kap_i;
      qt_q[0]  <= '0;
      sat_q[0] <= ({17'b0, d_i} >= {kap_i, 17'b0});
    end
  end

  for (genvar j = 1; j <= DivStages; j++) begin : g_step
    localparam int Hi = 34 - 2 * j;
    localparam int Lo = 33 - 2 * j;
    logic [64:0] dv_hi;
    logic        b_hi;
    logic [47:0] r_hi;
    logic [47:0] r_out;
    logic [32:0] q_out;

    assign dv_hi = {33'b0, kap_q[j-1]} << Hi;
    assign b_hi  = {17'b0, rem_q[j-1]} >= dv_hi;
    assign r_hi  = b_hi ? rem_q[j-1] - dv_hi[47:0] : rem_q[j-1];

    if (Lo >= 0) begin : g_two
      logic [64:0] dv_lo;
      logic        b_lo;
      assign dv_lo = {33'b0, kap_q[j-1]} << Lo;
      assign b_lo  = {17'b0, r_hi} >= dv_lo;
      assign r_out = b_lo ? r_hi - dv_lo[47:0] : r_hi;
      always_comb begin
        q_out     = qt_q[j-1];
        q_out[Hi] = b_hi;
        q_out[Lo] = b_lo;
      end
    end else begin : g_one
      assign r_out = r_hi;
      always_comb begin
        q_out     = qt_q[j-1];
        q_out[Hi] = b_hi;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= r_out;
        kap_q[j] <= kap_q[j-1];
        qt_q[j]  <= q_out;
        sat_q[j] <= sat_q[j-1];
      end
    end
  end

  assign q_o   = qt_q[DivStages];
  assign sat_o = sat_q[DivStages];

endmodule

`default_nettype wire

// ----- hw/rtl/tplw_exp2.sv -----
// Pipelined power of two of a 16-bit fraction as a product of repeated square roots of two.
`timescale 1ns / 1ps
`default_nettype none

module tplw_exp2 import tplw_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [15:0] f_i,
  input  logic [5:0]  nu_i,
  output logic [31:0] g_o,
  output logic [5:0]  nu_o
);

  logic [31:0] g_q  [1:ExpStages];
  logic [15:0] f_q  [1:ExpStages];
  logic [5:0]  nu_q [1:ExpStages];

  for (genvar k = 1; k <= ExpStages; k++) begin : g_mul
    localparam logic [31:0] Root = exp2_root(k);
    logic [31:0] g_in;
    logic [15:0] f_in;
    logic [5:0]  nu_in;
    logic [63:0] prod;

    if (k == 1) begin : g_first
      assign g_in  = 32'h4000_0000;
      assign f_in  = f_i;
      assign nu_in = nu_i;
    end else begin : g_next
      assign g_in  = g_q[k-1];
      assign f_in  = f_q[k-1];
      assign nu_in = nu_q[k-1];
    end

    assign prod = 64'(g_in) * 64'(Root) + 64'h2000_0000;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        g_q[k]  <= f_in[16-k] ? prod[61:30] : g_in;
        f_q[k]  <= f_in;
        nu_q[k] <= nu_in;
      end
    end
  end

  assign g_o  = g_q[ExpStages];
  assign nu_o = nu_q[ExpStages];

endmodule

`default_nettype wire

// ----- hw/rtl/truncated_power_law_weight.sv -----
// Top level of the truncated power-law movement weight pipeline.
`timescale 1ns / 1ps
`default_nettype none

// Gives one weight (d + r0)^-beta * exp(-d/kappa) in Q8.24 for each distance beat, with
// a saturation flag and the row-end marker passed along. The datapath is a fully
// pipelined chain of 39 register stages: one input stage, an 18-stage log2 (leading-one
// detect, normalise and 16 squarings) alongside a radix-4 divider of the same latency,
// three stages that scale and add the exponent, 16 multiply stages for the power of two
// and one output register. One distance is accepted every clock while the output side
// keeps taking results; a stall at the output holds the whole pipeline. Configuration
// registers should be written only while no beat is in flight.
module truncated_power_law_weight import tplw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] distance_i,
  input  logic        row_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] weight_o,
  output logic        clipped_o,
  output logic        row_end_out_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int Depth = FrontDepth + ExpStages + 5;
  localparam int M2Idx = FrontDepth + 2;

  logic        en;
  logic [Depth-1:0] vld_q;

  logic [31:0] offset_q;
  logic [15:0] decay_q;
  logic [31:0] cutoff_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= OFFSET_RST;
      decay_q  <= DECAY_RST;
      cutoff_q <= CUTOFF_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_OFFSET: offset_q <= cfg_data_i;
        CFG_DECAY:  decay_q  <= cfg_data_i[15:0];
        CFG_CUTOFF: cutoff_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign en         = !vld_q[Depth-1] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end

  // Input stage.
  logic [31:0] d_q;
  logic [32:0] s_q;
  logic [31:0] kap_q;
  side_t       sd_q [M2Idx+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_q      <= distance_i;
      s_q      <= {1'b0, distance_i} + {1'b0, offset_q};
      kap_q    <= (cutoff_q == 32'd0) ? 32'd1 : cutoff_q;
      sd_q[0]  <= '{row_end: row_end_i, dzero: (distance_i == 32'd0), beta: decay_q};
    end
  end

  for (genvar i = 1; i <= M2Idx; i++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en) begin
        sd_q[i] <= sd_q[i-1];
      end
    end
  end

  logic signed [22:0] l;
  logic [32:0]        q;
  logic               qsat;

  tplw_log2 u_log2 (
    .clk_i (clk_i),
    .en_i  (en),
    .s_i   (s_q),
    .l_o   (l)
  );

  tplw_div u_div (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (d_q),
    .kap_i (kap_q),
    .q_o   (q),
    .sat_o (qsat)
  );

  // Scale the logarithm by beta and the quotient by log2(e).
  logic [32:0]        qs;
  logic signed [39:0] prod_q;
  logic [47:0]        hi_q;
  logic [46:0]        lo_q;

  assign qs = (qsat || q > 33'h1_0000_0000) ? 33'h1_0000_0000 : q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= 40'($signed({1'b0, sd_q[FrontDepth].beta})) * 40'(l);
      hi_q   <= 48'(qs[32:16]) * 48'(LOG2E_Q30);
      lo_q   <= 47'(qs[15:0]) * 47'(LOG2E_Q30);
    end
  end

  logic [63:0]        csum;
  logic signed [39:0] pround;
  logic [33:0]        c_q;
  logic signed [27:0] p_q;

  assign csum   = {hi_q, 16'b0} + {17'b0, lo_q} + 64'h2000_0000;
  assign pround = (prod_q + 40'sd2048) >>> 12;

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_q <= csum[63:30];
      p_q <= pround[27:0];
    end
  end

  // Exponent of two and range classification.
  logic signed [35:0] x;
  logic signed [35:0] u;
  tail_t              ex_q [ExpStages+1];
  logic [15:0]        f_q;
  logic [5:0]         nu_q;

  assign x = -(36'(p_q) + $signed({2'b0, c_q}));
  assign u = x + 36'sd1638400;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ex_q[0] <= '{row_end: sd_q[M2Idx].row_end, dzero: sd_q[M2Idx].dzero,
                   big: (x >= 36'sd524288), tiny: (x < -36'sd1638400)};
      f_q     <= u[15:0];
      nu_q    <= u[21:16];
    end
  end

  for (genvar i = 1; i <= ExpStages; i++) begin : g_tail
    always_ff @(posedge clk_i) begin
      if (en) begin
        ex_q[i] <= ex_q[i-1];
      end
    end
  end

  logic [31:0] g;
  logic [5:0]  nu_e;

  tplw_exp2 u_exp2 (
    .clk_i (clk_i),
    .en_i  (en),
    .f_i   (f_q),
    .nu_i  (nu_q),
    .g_o   (g),
    .nu_o  (nu_e)
  );

  // Final scaling with rounding, then the output register.
  logic [32:0] w;
  logic [31:0] weight_q;
  logic        clipped_q;
  logic        row_end_q;

  always_comb begin
    if (nu_e >= 6'd31) begin
      w = {1'b0, g} << (nu_e - 6'd31);
    end else begin
      w = ({1'b0, g} + (33'd1 << (6'd30 - nu_e))) >> (6'd31 - nu_e);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      row_end_q <= ex_q[ExpStages].row_end;
      if (ex_q[ExpStages].dzero || ex_q[ExpStages].tiny) begin
        weight_q  <= '0;
        clipped_q <= 1'b0;
      end else if (ex_q[ExpStages].big || w[32]) begin
        weight_q  <= 32'hFFFF_FFFF;
        clipped_q <= 1'b1;
      end else begin
        weight_q  <= w[31:0];
        clipped_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = vld_q[Depth-1];
  assign weight_o      = weight_q;
  assign clipped_o     = clipped_q;
  assign row_end_out_o = row_end_q;

`ifndef SYNTHESIS
  a_clip_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clipped_o |-> weight_o == 32'hFFFF_FFFF)
    else $error("clipped result without full-scale weight");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline valid bits moved during a stall");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted beat did not enter the pipeline");
`endif

endmodule

`default_nettype wire
